@@ hdl/lslf_pkg.sv @@
// ----------------------------------------------------------------------------
// lslf_pkg
// Shared types and constants for the least-squares line fit unit.
// ----------------------------------------------------------------------------
package lslf_pkg;

    localparam int RES_W     = 32;
    localparam int CNT_OUT_W = 11;
    localparam int FRAC_BITS = 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_DIFF,
        S_DIV_INIT,
        S_DIV,
        S_DIV_END,
        S_OUT
    } t_back_state;

    typedef enum logic [2:0] {
        PR_SXSY,
        PR_NSXY,
        PR_SXYSX,
        PR_SXXSY,
        PR_SXSX,
        PR_NSXX
    } t_prod;

endpackage

@@ hdl/least_squares_line_fit_unit.sv @@
// ----------------------------------------------------------------------------
// least_squares_line_fit_unit
// Ordinary least-squares line fit over streamed point sets.
//
//   channel  | handshake     | payload
//   ---------+---------------+-------------------------------------------------
//   points   | push / full   | i_x_coord, i_y_coord, i_last_point
//   results  | pop / empty   | o_slope, o_intercept, o_degenerate,
//            |               | o_saturated, o_point_count
//
// Points transfer one per cycle into the accumulator while full is low. A
// set's sums go to a two-entry queue; the fit engine handles one set at a
// time (six shift-add products, two 32-step divisions; a degenerate set
// skips the divisions).
// full rises only while the queue holds two sets. Synchronous reset clears
// the sums, empties the queue and invalidates the result register.
// ----------------------------------------------------------------------------
module least_squares_line_fit_unit import lslf_pkg::*; #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [15:0]             i_x_coord,
    input  logic [15:0]             i_y_coord,
    input  logic                    i_last_point,
    output logic                    empty,
    input  logic                    pop,
    output logic signed [RES_W-1:0] o_slope,
    output logic signed [RES_W-1:0] o_intercept,
    output logic                    o_degenerate,
    output logic                    o_saturated,
    output logic [CNT_OUT_W-1:0]    o_point_count
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SX_W  = COORD_BITS + CNT_W;
    localparam int SXY_W = 2 * COORD_BITS + CNT_W;
    localparam int IW    = CNT_W + 2 * SX_W + 2 * SXY_W;

    logic          accept, q_push, q_pop, q_full, q_empty;
    logic [IW-1:0] q_wdata, q_rdata;

    assign full   = q_full;
    assign accept = push & ~q_full;

    lslf_front #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .CNT_W      (CNT_W),
        .SX_W       (SX_W),
        .SXY_W      (SXY_W),
        .IW         (IW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_x_coord    (i_x_coord),
        .i_y_coord    (i_y_coord),
        .i_last_point (i_last_point),
        .o_q_push     (q_push),
        .o_q_data     (q_wdata)
    );

    lslf_fifo #(
        .W (IW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    lslf_back #(
        .COORD_BITS (COORD_BITS),
        .CNT_W      (CNT_W),
        .SX_W       (SX_W),
        .SXY_W      (SXY_W),
        .IW         (IW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_data      (q_rdata),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_slope       (o_slope),
        .o_intercept   (o_intercept),
        .o_degenerate  (o_degenerate),
        .o_saturated   (o_saturated),
        .o_point_count (o_point_count)
    );

endmodule

@@ hdl/lslf_front.sv @@
// ----------------------------------------------------------------------------
// lslf_front
// Point accumulator: count and running sums, handed off at the set's end.
// ----------------------------------------------------------------------------
module lslf_front import lslf_pkg::*; #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 16,
    parameter int CNT_W      = 11,
    parameter int SX_W       = 27,
    parameter int SXY_W      = 43,
    parameter int IW         = 151
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [15:0]   i_x_coord,
    input  logic [15:0]   i_y_coord,
    input  logic          i_last_point,
    output logic          o_q_push,
    output logic [IW-1:0] o_q_data
);

    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [SX_W-1:0]         r_sx, r_sy, n_sx, n_sy;
    logic [SXY_W-1:0]        r_sxy, r_sxx, n_sxy, n_sxx;
    logic [COORD_BITS+15:0]  x_ext, y_ext;
    logic [COORD_BITS-1:0]   x_m, y_m;
    logic [2*COORD_BITS-1:0] p_xy, p_xx;
    logic                    room;

    always_comb begin
        x_ext = {{COORD_BITS{1'b0}}, i_x_coord};
        y_ext = {{COORD_BITS{1'b0}}, i_y_coord};
        x_m   = x_ext[COORD_BITS-1:0];
        y_m   = y_ext[COORD_BITS-1:0];
        p_xy  = x_m * y_m;
        p_xx  = x_m * x_m;
        room  = (r_cnt < CNT_W'(MAX_POINTS));
        n_cnt = r_cnt;
        n_sx  = r_sx;
        n_sy  = r_sy;
        n_sxy = r_sxy;
        n_sxx = r_sxx;
        if (room) begin
            n_cnt = r_cnt + 1'b1;
            n_sx  = r_sx + SX_W'(x_m);
            n_sy  = r_sy + SX_W'(y_m);
            n_sxy = r_sxy + SXY_W'(p_xy);
            n_sxx = r_sxx + SXY_W'(p_xx);
        end
    end

    assign o_q_push = i_accept & i_last_point;
    assign o_q_data = {n_cnt, n_sx, n_sy, n_sxy, n_sxx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxy <= '0;
            r_sxx <= '0;
        end else if (i_accept) begin
            if (i_last_point) begin
                r_cnt <= '0;
                r_sx  <= '0;
                r_sy  <= '0;
                r_sxy <= '0;
                r_sxx <= '0;
            end else begin
                r_cnt <= n_cnt;
                r_sx  <= n_sx;
                r_sy  <= n_sy;
                r_sxy <= n_sxy;
                r_sxx <= n_sxx;
            end
        end
    end

endmodule

@@ hdl/lslf_fifo.sv @@
// ----------------------------------------------------------------------------
// lslf_fifo
// Two-entry queue of finished set sums between front and back end.
// ----------------------------------------------------------------------------
module lslf_fifo import lslf_pkg::*; #(
    parameter int W = 151
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_empty,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ hdl/lslf_back.sv @@
// ----------------------------------------------------------------------------
// lslf_back
// Fit engine: serial shift-add products, restoring division, output register.
// ----------------------------------------------------------------------------
module lslf_back import lslf_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int CNT_W      = 11,
    parameter int SX_W       = 27,
    parameter int SXY_W      = 43,
    parameter int IW         = 151
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_empty,
    input  logic [IW-1:0]           i_q_data,
    output logic                    o_q_pop,
    input  logic                    i_pop,
    output logic                    o_empty,
    output logic signed [RES_W-1:0] o_slope,
    output logic signed [RES_W-1:0] o_intercept,
    output logic                    o_degenerate,
    output logic                    o_saturated,
    output logic [CNT_OUT_W-1:0]    o_point_count
);

    localparam int PW    = SXY_W + SX_W;
    localparam int DW    = PW + 40;
    localparam int NSH   = (COORD_BITS <= 16) ? 16 - COORD_BITS : 0;
    localparam int DSH   = (COORD_BITS > 16) ? COORD_BITS - 16 : 0;
    localparam int STEPS = (SXY_W > 32) ? SXY_W : 32;
    localparam int BIT_W = $clog2(STEPS);

    t_back_state r_state, n_state;
    t_prod       r_pidx, n_pidx;

    logic [CNT_W-1:0] r_n;
    logic [SX_W-1:0]  r_sx, r_sy;
    logic [SXY_W-1:0] r_sxy, r_sxx;

    logic [PW-1:0]    r_ma, r_macc, a_sel, acc_next;
    logic [SXY_W-1:0] r_mb, b_sel;
    logic [BIT_W-1:0] r_bit;
    logic [PW-1:0]    r_prod [6];

    logic [PW-1:0] r_n1, r_n2, r_den;
    logic          r_sn1, r_sn2, r_sd;
    logic [PW:0]   d1, d2, d3;

    logic [DW-1:0] r_num, r_dv, num_v, dsh_v, big_v;
    logic [32:0]   r_q, q_neg;
    logic          r_qsel, ge, q_neg_flag, q_sat;
    logic [RES_W-1:0] q_val;

    logic [RES_W-1:0] r_slope, r_icpt;
    logic             r_degen, r_sat;

    logic                    r_out_valid;
    logic [RES_W-1:0]        r_o_slope, r_o_icpt;
    logic                    r_o_degen, r_o_sat;
    logic [CNT_OUT_W-1:0]    r_o_cnt;
    logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;
    logic                    mul_last, div_last, out_load;

    // operand selection
    always_comb begin
        case (r_pidx)
            PR_SXSY:  begin a_sel = PW'(r_sx);  b_sel = SXY_W'(r_sy); end
            PR_NSXY:  begin a_sel = PW'(r_n);   b_sel = r_sxy;        end
            PR_SXYSX: begin a_sel = PW'(r_sxy); b_sel = SXY_W'(r_sx); end
            PR_SXXSY: begin a_sel = PW'(r_sxx); b_sel = SXY_W'(r_sy); end
            PR_SXSX:  begin a_sel = PW'(r_sx);  b_sel = SXY_W'(r_sx); end
            PR_NSXX:  begin a_sel = PW'(r_n);   b_sel = r_sxx;        end
            default:  begin a_sel = '0;         b_sel = '0;           end
        endcase
        case (r_pidx)
            PR_SXSY:  n_pidx = PR_NSXY;
            PR_NSXY:  n_pidx = PR_SXYSX;
            PR_SXYSX: n_pidx = PR_SXXSY;
            PR_SXXSY: n_pidx = PR_SXSX;
            PR_SXSX:  n_pidx = PR_NSXX;
            default:  n_pidx = PR_SXSY;
        endcase
    end

    always_comb begin
        acc_next = r_mb[0] ? r_macc + r_ma : r_macc;
        mul_last = (r_bit == BIT_W'(SXY_W - 1));
        div_last = (r_bit == BIT_W'(31));
        d1 = {1'b0, r_prod[PR_SXSY]}  - {1'b0, r_prod[PR_NSXY]};
        d2 = {1'b0, r_prod[PR_SXYSX]} - {1'b0, r_prod[PR_SXXSY]};
        d3 = {1'b0, r_prod[PR_SXSX]}  - {1'b0, r_prod[PR_NSXX]};
        num_v = r_qsel ? (DW'(r_n2) << NSH) : (DW'(r_n1) << FRAC_BITS);
        dsh_v = r_qsel ? (DW'(r_den) << DSH) : DW'(r_den);
        big_v = dsh_v << 32;
        ge    = (r_num >= r_dv);
        q_neg_flag = r_qsel ? (r_sn2 ^ r_sd) : (r_sn1 ^ r_sd);
        q_neg = 33'd0 - r_q;
        if (q_neg_flag) begin
            q_sat = (r_q > 33'h0_8000_0000);
            q_val = q_sat ? 32'h8000_0000 : q_neg[31:0];
        end else begin
            q_sat = (r_q > 33'h0_7FFF_FFFF);
            q_val = q_sat ? 32'h7FFF_FFFF : r_q[31:0];
        end
        cnt_ext = {{CNT_OUT_W{1'b0}}, r_n};
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (!i_q_empty) n_state = S_LOAD;
            S_LOAD:     n_state = S_MUL;
            S_MUL: begin
                if (mul_last) n_state = (r_pidx == PR_NSXX) ? S_DIFF : S_LOAD;
            end
            S_DIFF:     n_state = (d3 == '0) ? S_OUT : S_DIV_INIT;
            S_DIV_INIT: n_state = (num_v >= big_v) ? S_DIV_END : S_DIV;
            S_DIV:      if (div_last) n_state = S_DIV_END;
            S_DIV_END:  n_state = r_qsel ? S_OUT : S_DIV_INIT;
            S_OUT:      if (!r_out_valid) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_q_pop  = (r_state == S_IDLE) && !i_q_empty;
        out_load = (r_state == S_OUT) && !r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                {r_n, r_sx, r_sy, r_sxy, r_sxx} <= i_q_data;
                r_pidx  <= PR_SXSY;
                r_slope <= '0;
                r_icpt  <= '0;
                r_degen <= 1'b0;
                r_sat   <= 1'b0;
                r_qsel  <= 1'b0;
            end
            S_LOAD: begin
                r_ma   <= a_sel;
                r_mb   <= b_sel;
                r_macc <= '0;
                r_bit  <= '0;
            end
            S_MUL: begin
                r_macc <= acc_next;
                r_ma   <= r_ma << 1;
                r_mb   <= r_mb >> 1;
                r_bit  <= r_bit + 1'b1;
                if (mul_last) begin
                    r_prod[r_pidx] <= acc_next;
                    r_pidx         <= n_pidx;
                end
            end
            S_DIFF: begin
                r_sn1 <= d1[PW];
                r_sn2 <= d2[PW];
                r_sd  <= d3[PW];
                r_n1  <= d1[PW] ? r_prod[PR_NSXY] - r_prod[PR_SXSY] : d1[PW-1:0];
                r_n2  <= d2[PW] ? r_prod[PR_SXXSY] - r_prod[PR_SXYSX] : d2[PW-1:0];
                r_den <= d3[PW] ? r_prod[PR_NSXX] - r_prod[PR_SXSX] : d3[PW-1:0];
                r_degen <= (d3 == '0);
            end
            S_DIV_INIT: begin
                r_num <= num_v;
                r_dv  <= dsh_v << 31;
                r_bit <= '0;
                r_q   <= (num_v >= big_v) ? 33'h1_0000_0000 : 33'd0;
            end
            S_DIV: begin
                if (ge) begin
                    r_num <= r_num - r_dv;
                end
                r_dv  <= r_dv >> 1;
                r_q   <= {r_q[31:0], ge};
                r_bit <= r_bit + 1'b1;
            end
            S_DIV_END: begin
                if (r_qsel) begin
                    r_icpt <= q_val;
                end else begin
                    r_slope <= q_val;
                end
                r_sat  <= r_sat | q_sat;
                r_qsel <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_slope <= r_slope;
            r_o_icpt  <= r_icpt;
            r_o_degen <= r_degen;
            r_o_sat   <= r_sat;
            r_o_cnt   <= cnt_ext[CNT_OUT_W-1:0];
        end
    end

    assign o_empty       = ~r_out_valid;
    assign o_slope       = r_o_slope;
    assign o_intercept   = r_o_icpt;
    assign o_degenerate  = r_o_degen;
    assign o_saturated   = r_o_sat;
    assign o_point_count = r_o_cnt;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the least-squares line fit unit. A directed table
// covers single points, vertical sets, saturation both ways and exact lines;
// random point sets follow, mostly noisy lines. One set runs past the point
// limit. Fits are checked field by field vs the table or a local line fitter.
// ----------------------------------------------------------------------------
module testbench;
    import lslf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PTS    = 1024;
    localparam int N_RANDOM   = 1330;
    localparam int N_LONG     = MAX_PTS + 6;
    localparam int N_SHORT    = N_RANDOM - N_LONG;
    localparam int STALL_LIM  = 5000;

    typedef struct {
        logic signed [RES_W-1:0] slope;
        logic signed [RES_W-1:0] icpt;
        logic                    degen;
        logic                    sat;
        logic [CNT_OUT_W-1:0]    cnt;
    } fit_t;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic        last;
        bit          typed;
        fit_t        fit;
    } row_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    push = 1'b0;
    logic                    full;
    logic [15:0]             i_x_coord = '0;
    logic [15:0]             i_y_coord = '0;
    logic                    i_last_point = 1'b0;
    logic                    empty;
    logic                    pop = 1'b0;
    logic signed [RES_W-1:0] o_slope;
    logic signed [RES_W-1:0] o_intercept;
    logic                    o_degenerate;
    logic                    o_saturated;
    logic [CNT_OUT_W-1:0]    o_point_count;

    least_squares_line_fit_unit i_dut (.*);

    always #6 i_clk = ~i_clk;

    // running sums of the open set
    logic [127:0] sum_x, sum_y, sum_xy, sum_xx;
    int           pt_count;

    fit_t pending_fits[$];
    row_t dir_rows[$];
    int   errors = 0;
    int   fits_seen = 0;
    int   points_sent = 0;
    int   send_idle = 34;
    int   recv_idle = 47;
    int   quiet_cycles = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH fit %0d %s: got %h want %h", fits_seen, what, got, want);
        errors++;
    endtask

    function automatic logic [127:0] abs_diff(input logic [127:0] a, input logic [127:0] b,
                                              output bit neg);
        neg = a < b;
        return neg ? b - a : a - b;
    endfunction

    function automatic logic [31:0] clip_quot(input logic [127:0] num, input logic [127:0] den,
                                              input bit neg, inout bit sat);
        logic [127:0] q;
        q = num / den;
        if (q > 128'h1_0000_0000) q = 128'h1_0000_0000;
        if (neg) begin
            if (q > 128'h8000_0000) begin
                sat = 1'b1;
                return 32'h8000_0000;
            end
            return -q[31:0];
        end
        if (q > 128'h7FFF_FFFF) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        return q[31:0];
    endfunction

    // adds one point; returns 1 with the fit when the point closes the set
    function automatic bit add_point(input logic [15:0] x, input logic [15:0] y,
                                     input logic last, output fit_t f);
        logic [127:0] n1, n2, den, n;
        bit s1, s2, sd, sat;
        f = '{default: '0};
        if (pt_count < MAX_PTS) begin
            sum_x  += x;
            sum_y  += y;
            sum_xy += x * y;
            sum_xx += x * x;
            pt_count++;
        end
        if (!last) return 0;
        n   = pt_count;
        n1  = abs_diff(sum_x * sum_y, n * sum_xy, s1);
        n2  = abs_diff(sum_xy * sum_x, sum_xx * sum_y, s2);
        den = abs_diff(sum_x * sum_x, n * sum_xx, sd);
        sat = 1'b0;
        if (den == 0) begin
            f.degen = 1'b1;
        end else begin
            f.slope = clip_quot(n1 << FRAC_BITS, den, s1 != sd, sat);
            f.icpt  = clip_quot(n2, den, s2 != sd, sat);
        end
        f.sat = sat;
        f.cnt = pt_count[CNT_OUT_W-1:0];
        sum_x = 0; sum_y = 0; sum_xy = 0; sum_xx = 0; pt_count = 0;
        return 1;
    endfunction

    task automatic send_point(input logic [15:0] x, input logic [15:0] y, input logic last,
                              input bit typed, input fit_t typed_fit);
        fit_t f;
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_x_coord    <= x;
        i_y_coord    <= y;
        i_last_point <= last;
        do @(posedge i_clk); while (full);
        points_sent++;
        if (add_point(x, y, last, f)) pending_fits.push_back(typed ? typed_fit : f);
    endtask

    task automatic add_row(input logic [15:0] x, input logic [15:0] y, input logic last,
                           input bit typed, input fit_t f);
        dir_rows.push_back('{x, y, last, typed, f});
    endtask

    task automatic send_set(input int len, input int kind);
        logic [15:0] x, y, x0, y0;
        int k;
        fit_t none;
        none = '{default: '0};
        x0 = 16'($urandom);
        y0 = 16'($urandom);
        k  = $urandom_range(0, 511) - 256;
        for (int i = 0; i < len; i++) begin
            x = (kind == 2) ? x0 : 16'($urandom);
            case (kind)
                0: y = 16'(y0 + ((int'(x) * k) >>> 8) + $urandom_range(0, 63));
                3: y = 16'($urandom_range(0, 3));
                default: y = 16'($urandom);
            endcase
            send_point(x, y, i == len - 1, 0, none);
        end
    endtask

    task automatic drain();
        while (pending_fits.size() != 0) @(posedge i_clk);
    endtask

    // result side: check on transfer, then pick next pop
    always @(posedge i_clk) begin
        fit_t e;
        if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
        else if (i_rst_n) quiet_cycles++;
        if (quiet_cycles >= STALL_LIM) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIM);
            $display("end of test: mismatches");
            $finish;
        end
        if (pop && !empty) begin
            if (pending_fits.size() == 0) begin
                report("unexpected result", o_slope, 0);
            end else begin
                e = pending_fits.pop_front();
                if (o_slope !== e.slope) report("slope", o_slope, e.slope);
                if (o_intercept !== e.icpt) report("intercept", o_intercept, e.icpt);
                if (o_degenerate !== e.degen) report("degenerate", o_degenerate, e.degen);
                if (o_saturated !== e.sat) report("saturated", o_saturated, e.sat);
                if (o_point_count !== e.cnt) report("point_count", o_point_count, e.cnt);
            end
            fits_seen++;
        end
        pop <= i_rst_n && ($urandom_range(99) >= recv_idle);
    end

    initial begin
        fit_t f;
        int   n_rand, n_short, len, kind;
        bit   long_done;
        sum_x = 0; sum_y = 0; sum_xy = 0; sum_xx = 0; pt_count = 0;
        f = '{default: '0};

        add_row(0, 0, 1, 1, '{0, 0, 1, 0, 1});
        add_row(16'hFFFF, 16'hFFFF, 1, 1, '{0, 0, 1, 0, 1});
        add_row(7, 0, 0, 0, f);
        add_row(7, 16'hFFFF, 0, 0, f);
        add_row(7, 100, 1, 1, '{0, 0, 1, 0, 3});
        add_row(0, 0, 0, 0, f);
        add_row(1, 16'hFFFF, 1, 1, '{32'h7FFF_FFFF, 0, 0, 1, 2});
        add_row(0, 16'hFFFF, 0, 0, f);
        add_row(1, 0, 1, 1, '{32'h8000_0000, 65535, 0, 1, 2});
        add_row(0, 0, 0, 0, f);
        add_row(100, 100, 0, 0, f);
        add_row(16'hFFFF, 16'hFFFF, 1, 1, '{65536, 0, 0, 0, 3});
        add_row(16'hFFFF, 0, 0, 0, f);
        add_row(0, 16'hFFFF, 1, 1, '{-65536, 65535, 0, 0, 2});
        add_row(40000, 20000, 0, 0, f);
        add_row(12345, 16'hFFFF, 0, 0, f);
        add_row(16'hFFFF, 1, 1, 0, f);
        add_row(16'h5555, 16'hAAAA, 0, 0, f);
        add_row(16'hAAAA, 16'h5555, 1, 0, f);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].last,
                       dir_rows[i].typed, dir_rows[i].fit);
        push <= 1'b0;
        @(posedge i_clk);
        drain();

        n_rand = 0;
        n_short = 0;
        long_done = 0;
        while (n_rand < N_RANDOM) begin
            if (n_short >= 2 * N_SHORT / 3) begin
                send_idle = 0; recv_idle = 0;
            end else if (n_short >= N_SHORT / 3) begin
                send_idle = 47; recv_idle = 34;
            end
            if (!long_done && n_short >= 2 * N_SHORT / 3 + 20) begin
                len = N_LONG;
                kind = 1;
                long_done = 1;
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
                                                  : $urandom_range(1, 8);
                case ($urandom_range(0, 19))
                    0, 1:     kind = 2;
                    2, 3, 4:  kind = 1;
                    5:        kind = 3;
                    default:  kind = 0;
                endcase
                n_short += len;
            end
            send_set(len, kind);
            n_rand += len;
        end
        push <= 1'b0;
        @(posedge i_clk);

        drain();
        repeat (800) @(posedge i_clk);
        $display("sent %0d points in directed and random sets, %0d fits checked",
                 points_sent, fits_seen);
        $display("covered degenerate, saturated, exact-line and over-limit sets");
        if (errors == 0 && pending_fits.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

@@ files.f @@
hdl/lslf_pkg.sv
hdl/lslf_front.sv
hdl/lslf_fifo.sv
hdl/lslf_back.sv
hdl/least_squares_line_fit_unit.sv
tb/testbench.sv
